@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the string-to-integer parse core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_HOLDS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("parser property violated");

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, cond, prop) \
    `ASSERT_HOLDS(label, (cond) |-> (prop))

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, cond, prop) \
    `ASSERT_HOLDS(label, (cond) |=> (prop))

`endif

@@ hw/rtl/s2i_pkg.sv @@
// Types, codes and character helpers for the string-to-integer parser.
package s2i_pkg;

    localparam logic [5:0]  MaxRadix    = 6'd36;
    localparam logic [7:0]  NoDigit     = 8'd255;
    localparam logic [7:0]  ChMinus     = 8'h2D;
    localparam logic [7:0]  ChPlus      = 8'h2B;
    localparam logic [7:0]  ChZero      = 8'h30;
    localparam logic [7:0]  ChLowerX    = 8'h78;
    localparam logic [7:0]  ChUpperX    = 8'h58;
    localparam logic [63:0] MagLimitPos = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MagLimitNeg = 64'h8000_0000_0000_0000;
    localparam logic [5:0]  BaseDefault = 6'd10;

    // Result status codes
    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StRange  = 2'd1;
    localparam logic [1:0] StNoConv = 2'd2;

    typedef enum logic [5:0] {
        PH_SPACE  = 6'b000001,
        PH_SIGN   = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_PREFIX = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } s2i_phase_t;

    // One text word held in the input register
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } s2i_word_t;

    // One conversion result handed to the output register
    typedef struct packed {
        logic        valid;
        logic [63:0] value;
        logic [1:0]  status;
    } s2i_result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // Digit value of 0-9, A-Z, a-z; NoDigit for anything else
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = NoDigit;
        if ((c >= 8'h30) && (c <= 8'h39)) d = c - 8'h30;
        else if ((c >= 8'h41) && (c <= 8'h5A)) d = c - 8'h37;
        else if ((c >= 8'h61) && (c <= 8'h7A)) d = c - 8'h57;
        return d;
    endfunction

    function automatic logic bad_base(input logic [5:0] b);
        return (b < 6'd2) || (b > MaxRadix);
    endfunction

endpackage

@@ hw/rtl/s2i_in_reg.sv @@
// Input register stage of the string-to-integer parser.
module s2i_in_reg
    import s2i_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] char_byte,
    input  logic      last_char,
    input  logic      out_free,
    output s2i_word_t word,
    output logic      advance
);

    logic      vld_reg;
    logic      vld_next;
    s2i_word_t word_reg;

    // Advance a held word unless it ends a string and the result slot is busy
    assign advance  = vld_reg && (!word_reg.last || out_free);
    assign in_ready = !vld_reg || advance;
    assign word     = word_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Capture the payload on acceptance
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg.ch   <= char_byte;
            word_reg.last <= last_char;
        end
    end

endmodule

@@ hw/rtl/s2i_parse_core.sv @@
// Parse state, radix register and per-byte conversion step.
`include "assert_macros.svh"

module s2i_parse_core
    import s2i_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [5:0]  number_base,
    input  logic        advance,
    input  s2i_word_t   word,
    output s2i_result_t res
);

    s2i_phase_t  phase_reg, phase_next, phase_upd;
    logic [63:0] mag_reg, mag_next, mag_upd;
    logic        neg_reg, neg_next, neg_upd;
    logic        digit_reg, digit_next, digit_upd;
    logic        ovf_reg, ovf_next, ovf_upd;
    logic [5:0]  base_reg, base_next, base_upd;
    logic [5:0]  cfg_base_reg;

    logic        as_sign;
    logic        take;
    logic [7:0]  dval;
    logic [63:0] limit;
    logic [69:0] acc;
    logic        res_fire;

    assign dval     = digit_value(word.ch);
    assign res_fire = advance && word.last;

    // Hold the radix register; writes are to come only while idle, which the block does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_base_reg <= BaseDefault;
        end
        else if (cfg_valid)
        begin
            cfg_base_reg <= number_base;
        end
    end

    // Step the parse state by one byte
    always_comb
    begin
        phase_upd = phase_reg;
        mag_upd   = mag_reg;
        neg_upd   = neg_reg;
        digit_upd = digit_reg;
        ovf_upd   = ovf_reg;
        base_upd  = base_reg;
        as_sign   = 1'b0;
        take      = 1'b0;
        limit     = MagLimitPos;
        acc       = '0;

        unique case (phase_reg)
            PH_SPACE:
            begin
                if (!is_blank(word.ch))
                begin
                    base_upd  = cfg_base_reg;
                    phase_upd = PH_SIGN;
                    if (word.ch == ChMinus)
                    begin
                        neg_upd = 1'b1;
                    end
                    else if (word.ch != ChPlus)
                    begin
                        as_sign = 1'b1;
                    end
                end
            end
            PH_SIGN:
            begin
                as_sign = 1'b1;
            end
            PH_ZERO:
            begin
                if ((word.ch == ChLowerX) || (word.ch == ChUpperX))
                begin
                    phase_upd = PH_PREFIX;
                end
                else
                begin
                    if (base_upd == 6'd0) base_upd = 6'd8;
                    phase_upd = PH_DIGITS;
                    take      = 1'b1;
                end
            end
            PH_PREFIX:
            begin
                if (dval < 8'd16)
                begin
                    base_upd  = 6'd16;
                    phase_upd = PH_DIGITS;
                    take      = 1'b1;
                end
                else
                begin
                    phase_upd = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                take = 1'b1;
            end
            default:
            begin
                // done: drop trailing bytes
            end
        endcase

        // First byte after any sign: reject a bad radix, else pick prefix handling or radix
        if (as_sign)
        begin
            if ((base_upd != 6'd0) && bad_base(base_upd))
            begin
                phase_upd = PH_DONE;
            end
            else if ((word.ch == ChZero) && ((base_upd == 6'd0) || (base_upd == 6'd16)))
            begin
                digit_upd = 1'b1;
                phase_upd = PH_ZERO;
            end
            else
            begin
                if (base_upd == 6'd0) base_upd = 6'd10;
                phase_upd = PH_DIGITS;
                take      = 1'b1;
            end
        end

        // Accumulate one digit, or end the parse on a non-digit; overflow is mag*base + d beyond the limit
        if (take)
        begin
            if (bad_base(base_upd) || (dval >= {2'b00, base_upd}))
            begin
                phase_upd = PH_DONE;
            end
            else
            begin
                limit = neg_upd ? MagLimitNeg : MagLimitPos;
                acc   = ({6'd0, mag_reg} * {64'd0, base_upd}) + {62'd0, dval};
                if (ovf_reg || (acc > {6'd0, limit}))
                begin
                    ovf_upd = 1'b1;
                end
                else
                begin
                    mag_upd = acc[63:0];
                end
                digit_upd = 1'b1;
            end
        end
    end

    // Form the result from the updated state
    always_comb
    begin
        res.valid = res_fire;
        if (!digit_upd)
        begin
            res.value  = 64'd0;
            res.status = StNoConv;
        end
        else if (ovf_upd)
        begin
            res.value  = neg_upd ? MagLimitNeg : MagLimitPos;
            res.status = StRange;
        end
        else
        begin
            res.value  = neg_upd ? (64'd0 - mag_upd) : mag_upd;
            res.status = StOk;
        end
    end

    // Commit the step, or clear for the next string after a result
    always_comb
    begin
        phase_next = phase_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        digit_next = digit_reg;
        ovf_next   = ovf_reg;
        base_next  = base_reg;
        if (res_fire)
        begin
            phase_next = PH_SPACE;
            mag_next   = 64'd0;
            neg_next   = 1'b0;
            digit_next = 1'b0;
            ovf_next   = 1'b0;
            base_next  = 6'd0;
        end
        else if (advance)
        begin
            phase_next = phase_upd;
            mag_next   = mag_upd;
            neg_next   = neg_upd;
            digit_next = digit_upd;
            ovf_next   = ovf_upd;
            base_next  = base_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            mag_reg   <= 64'd0;
            neg_reg   <= 1'b0;
            digit_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            base_reg  <= 6'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            digit_reg <= digit_next;
            ovf_reg   <= ovf_next;
            base_reg  <= base_next;
        end
    end

    `ASSERT_NEXT(a_clear_after_result, res_fire, phase_reg == PH_SPACE && !digit_reg)
    `ASSERT_IMPLIES(a_ovf_has_digit, ovf_reg, digit_reg)
    `ASSERT_IMPLIES(a_digits_base_ok, phase_reg == PH_DIGITS, !bad_base(base_reg))
    `ASSERT_HOLDS(a_mag_bound, mag_reg <= MagLimitNeg)

endmodule

@@ hw/rtl/s2i_out_reg.sv @@
// Result register stage of the string-to-integer parser.
module s2i_out_reg
    import s2i_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  s2i_result_t        res,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] value,
    output logic [1:0]         status,
    output logic               out_free
);

    logic        vld_reg;
    logic        vld_next;
    logic [63:0] value_reg;
    logic [1:0]  status_reg;

    assign out_free  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign value     = $signed(value_reg);
    assign status    = status_reg;

    // Load a new result, or drop the held one when taken
    always_comb
    begin
        vld_next = vld_reg && !out_ready;
        if (res.valid)
        begin
            vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            value_reg  <= res.value;
            status_reg <= res.status;
        end
    end

endmodule

@@ hw/rtl/string_to_int64_parser.sv @@
// Top level of the streaming strtoll-style string to int64 parser.
// Takes one text byte per clock on the in channel, unless stalled, and
// returns one signed 64-bit value with a status word (0 ok, 1 clamped
// out of range, 2 no conversion or bad radix) after the byte marked
// last_char. Sustained rate is one byte per cycle without stalls; a byte
// is held in the input register, then the multiply-by-radix and add step
// updates the parse state and loads the result register, which gives
// out_valid. A last byte waits in the input register while an unread
// result holds the result register, and the input stalls meanwhile.
// The radix register (number_base, reset 10, 0 for auto-detect) is sampled
// at the first non-blank byte of each string and should be written only
// while the block is idle; cfg_ready is always high.
module string_to_int64_parser
    import s2i_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [5:0]         number_base,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_byte,
    input  logic               last_char,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] value,
    output logic [1:0]         status
);

    s2i_word_t   word;
    s2i_result_t res;
    logic        advance;
    logic        out_free;

    assign cfg_ready = 1'b1;

    s2i_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_byte (char_byte),
        .last_char (last_char),
        .out_free  (out_free),
        .word      (word),
        .advance   (advance)
    );

    s2i_parse_core u_parse_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .number_base (number_base),
        .advance     (advance),
        .word        (word),
        .res         (res)
    );

    s2i_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status),
        .out_free  (out_free)
    );

endmodule
